/* hdl/sch_pkg.sv */
package sch_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int RAD_WIDTH   = COORD_WIDTH - 1;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;          // start-end, start-center
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;           // one square or cross term
    localparam int HALF_WIDTH  = COORD_WIDTH + 2;          // half of a magnitude
    localparam int SUM_WIDTH   = 2 * HALF_WIDTH;           // a, h, c (signed)
    localparam int MAG_WIDTH   = SUM_WIDTH;                // |h|, a, c as magnitudes
    localparam int G_WIDTH     = SUM_WIDTH + 2;            // g(1) = a + 2h + c
    localparam int PP_WIDTH    = 2 * HALF_WIDTH;           // partial product
    localparam int SQ_WIDTH    = 2 * MAG_WIDTH;            // h*h and a*c
    localparam int QDEPTH      = 4;
    localparam int QADDR_WIDTH = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] center_x;
        logic signed [COORD_WIDTH-1:0] center_y;
        logic        [RAD_WIDTH-1:0]   radius;
    } in_item_t;

    typedef struct packed {
        logic hit;
        logic degenerate;
    } out_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [DIFF_WIDTH-1:0] dx;
        logic signed [DIFF_WIDTH-1:0] dy;
        logic signed [DIFF_WIDTH-1:0] fx;
        logic signed [DIFF_WIDTH-1:0] fy;
        logic        [RAD_WIDTH-1:0]  r;
        logic                         degen;
    } fe_item_t;

endpackage

/* hdl/sch_front.sv */
module sch_front
    import sch_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      q_valid,
    input  logic      q_ready,
    output fe_item_t  q_data
);

    logic     valid_reg;
    fe_item_t item_reg;
    fe_item_t item_next;

    always_comb
    begin
        item_next.dx    = DIFF_WIDTH'(in_data.end_x)   - DIFF_WIDTH'(in_data.start_x);
        item_next.dy    = DIFF_WIDTH'(in_data.end_y)   - DIFF_WIDTH'(in_data.start_y);
        item_next.fx    = DIFF_WIDTH'(in_data.start_x) - DIFF_WIDTH'(in_data.center_x);
        item_next.fy    = DIFF_WIDTH'(in_data.start_y) - DIFF_WIDTH'(in_data.center_y);
        item_next.r     = in_data.radius;
        item_next.degen = (in_data.start_x == in_data.end_x) &&
                          (in_data.start_y == in_data.end_y);
    end

    assign in_ready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_data   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* hdl/sch_queue.sv */
module sch_queue
    import sch_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  fe_item_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output fe_item_t pop_data
);

    fe_item_t               mem [QDEPTH];
    logic [QADDR_WIDTH-1:0] wr_ptr_reg;
    logic [QADDR_WIDTH-1:0] rd_ptr_reg;
    logic [QADDR_WIDTH:0]   count_reg;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != (QADDR_WIDTH+1)'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QADDR_WIDTH+1)'(QDEPTH))
        else $error("queue count over depth");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QADDR_WIDTH-1:0])
        else $error("queue pointers disagree with count");

endmodule

/* hdl/sch_back.sv */
module sch_back
    import sch_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_ready,
    input  fe_item_t  q_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int NSTAGE = 6;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-2:0] degen_reg;
    logic              en;

    // stage 1: squares and cross terms
    logic signed [PROD_WIDTH-1:0] pxx_reg, pyy_reg, pfxd_reg, pfyd_reg, pff_reg, pgg_reg;
    logic        [2*RAD_WIDTH-1:0] prr_reg;
    // stage 2: quadratic coefficients
    logic signed [SUM_WIDTH-1:0]  a_reg, h_reg, c_reg;
    // stage 3: range tests and magnitudes
    logic signed [G_WIDTH-1:0]    g1;
    logic [MAG_WIDTH-1:0]         hmag_reg, amag_reg, cmag_reg;
    logic                         top_reg, bot_reg, cpos_reg;
    logic                         top_next, bot_next;
    // stage 4: partial products
    logic [PP_WIDTH-1:0]          hhh_reg, hhl_reg, hll_reg;
    logic [PP_WIDTH-1:0]          ahch_reg, ahcl_reg, alch_reg, alcl_reg;
    logic [2:0]                   flag4_reg;
    // stage 5: h*h and a*c
    logic [SQ_WIDTH-1:0]          hsq_reg, ac_reg;
    logic [2:0]                   flag5_reg;
    // stage 6: result
    out_item_t                    res_reg;

    assign en        = !v_reg[NSTAGE-1] || out_ready;
    assign q_ready   = en;
    assign out_valid = v_reg[NSTAGE-1];
    assign out_data  = res_reg;

    always_comb
    begin
        g1       = G_WIDTH'(a_reg) + G_WIDTH'(c_reg) + (G_WIDTH'(h_reg) <<< 1);
        top_next = !c_reg[SUM_WIDTH-1] || !g1[G_WIDTH-1];
        if ((h_reg[SUM_WIDTH-1] || (h_reg == '0)) &&
            !((a_reg + h_reg) < 0))
        begin
            bot_next = 1'b1;            // vertex within [0,1]
        end
        else
        begin
            bot_next = c_reg[SUM_WIDTH-1] || (c_reg == '0) ||
                       g1[G_WIDTH-1] || (g1 == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= {degen_reg[NSTAGE-3:0], q_data.degen};

            pxx_reg  <= PROD_WIDTH'(q_data.dx) * PROD_WIDTH'(q_data.dx);
            pyy_reg  <= PROD_WIDTH'(q_data.dy) * PROD_WIDTH'(q_data.dy);
            pfxd_reg <= PROD_WIDTH'(q_data.fx) * PROD_WIDTH'(q_data.dx);
            pfyd_reg <= PROD_WIDTH'(q_data.fy) * PROD_WIDTH'(q_data.dy);
            pff_reg  <= PROD_WIDTH'(q_data.fx) * PROD_WIDTH'(q_data.fx);
            pgg_reg  <= PROD_WIDTH'(q_data.fy) * PROD_WIDTH'(q_data.fy);
            prr_reg  <= (2*RAD_WIDTH)'(q_data.r) * (2*RAD_WIDTH)'(q_data.r);

            a_reg <= SUM_WIDTH'(pxx_reg) + SUM_WIDTH'(pyy_reg);
            h_reg <= SUM_WIDTH'(pfxd_reg) + SUM_WIDTH'(pfyd_reg);
            c_reg <= SUM_WIDTH'(pff_reg) + SUM_WIDTH'(pgg_reg)
                     - SUM_WIDTH'({1'b0, prr_reg});

            // q >= 0 is certain when c <= 0, since a > 0
            top_reg  <= top_next;
            bot_reg  <= bot_next;
            cpos_reg <= !c_reg[SUM_WIDTH-1] && (c_reg != '0);
            hmag_reg <= h_reg[SUM_WIDTH-1] ? MAG_WIDTH'(-h_reg) : MAG_WIDTH'(h_reg);
            amag_reg <= MAG_WIDTH'(a_reg);
            cmag_reg <= MAG_WIDTH'(c_reg);

            hhh_reg  <= PP_WIDTH'(hmag_reg[MAG_WIDTH-1:HALF_WIDTH])
                        * PP_WIDTH'(hmag_reg[MAG_WIDTH-1:HALF_WIDTH]);
            hhl_reg  <= PP_WIDTH'(hmag_reg[MAG_WIDTH-1:HALF_WIDTH])
                        * PP_WIDTH'(hmag_reg[HALF_WIDTH-1:0]);
            hll_reg  <= PP_WIDTH'(hmag_reg[HALF_WIDTH-1:0])
                        * PP_WIDTH'(hmag_reg[HALF_WIDTH-1:0]);
            ahch_reg <= PP_WIDTH'(amag_reg[MAG_WIDTH-1:HALF_WIDTH])
                        * PP_WIDTH'(cmag_reg[MAG_WIDTH-1:HALF_WIDTH]);
            ahcl_reg <= PP_WIDTH'(amag_reg[MAG_WIDTH-1:HALF_WIDTH])
                        * PP_WIDTH'(cmag_reg[HALF_WIDTH-1:0]);
            alch_reg <= PP_WIDTH'(amag_reg[HALF_WIDTH-1:0])
                        * PP_WIDTH'(cmag_reg[MAG_WIDTH-1:HALF_WIDTH]);
            alcl_reg <= PP_WIDTH'(amag_reg[HALF_WIDTH-1:0])
                        * PP_WIDTH'(cmag_reg[HALF_WIDTH-1:0]);
            flag4_reg <= {top_reg, bot_reg, cpos_reg};

            hsq_reg <= (SQ_WIDTH'(hhh_reg) << (2*HALF_WIDTH))
                       + (SQ_WIDTH'(hhl_reg) << (HALF_WIDTH+1))
                       + SQ_WIDTH'(hll_reg);
            ac_reg  <= (SQ_WIDTH'(ahch_reg) << (2*HALF_WIDTH))
                       + ((SQ_WIDTH'(ahcl_reg) + SQ_WIDTH'(alch_reg)) << HALF_WIDTH)
                       + SQ_WIDTH'(alcl_reg);
            flag5_reg <= flag4_reg;

            res_reg.degenerate <= degen_reg[NSTAGE-2];
            res_reg.hit        <= !degen_reg[NSTAGE-2] && flag5_reg[2] && flag5_reg[1] &&
                                  (!flag5_reg[0] || (hsq_reg >= ac_reg));
        end
    end

    a_no_hit_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.degenerate))
        else $error("hit reported on zero-length segment");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(v_reg) && out_valid)
        else $error("pipeline moved while output stalled");

endmodule

/* hdl/segment_circle_hit_test.sv */
// Segment / circle hit test.
// Input channel in_valid/in_ready/in_data carries one item: a segment
// (start, end) and a circle (center, radius), signed 16-bit coordinates with
// 4 fraction bits. Output channel out_valid/out_ready/out_data returns one
// item per input: hit (a root of the segment-circle quadratic lies in [0,1])
// and degenerate (start equals end; hit is then 0).
// The decision is exact: wide products, no rounding.
// Structure: a front register forms differences and flags zero-length
// segments, a 4-entry queue decouples it from a 6-stage back pipeline
// (products, coefficients, range tests, split partial products of h*h and
// a*c, their sums, final compare).
// Throughput: one item per cycle while out_ready is high. An accepted item
// passes the front register, a queue slot and the six stages to out_valid;
// items waiting ahead of it in the queue delay it further.
// With out_valid high and out_ready low the back pipeline holds; the queue
// then fills and in_ready drops once queue and front register are full.
// No item is lost. Reset (rst_n, asynchronous, active low) empties all
// stages and the queue; no state persists between items.
module segment_circle_hit_test
    import sch_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    // front to queue
    logic     fq_valid;
    logic     fq_ready;
    fe_item_t fq_data;
    // queue to back
    logic     qb_valid;
    logic     qb_ready;
    fe_item_t qb_data;

    sch_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_data   (fq_data)
    );

    sch_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    sch_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
